/* design/dft14_complex_butterfly_assert.svh */
// Assertion macros for the 14-point DFT block.
// Included by the top level; depends on nothing else.
`ifndef DFT14_COMPLEX_BUTTERFLY_ASSERT_SVH
`define DFT14_COMPLEX_BUTTERFLY_ASSERT_SVH

// Implication checked every clock once reset is released.
`define DFT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DFT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/dft14_pkg.sv */
// Shared types and constants of the 14-point DFT block.
// No dependencies.
package dft14_pkg;

  localparam int FRAME_LEN = 14;

  // Q1.31 twiddle magnitudes: 0, 1, cos/sin of pi/7, 2pi/7, 3pi/7.
  localparam logic [31:0] Q31_MAG [8] = '{
    32'd0, 32'd2147483648, 32'd1934815911, 32'd931758235,
    32'd1338934154, 32'd1678970324, 32'd477860067, 32'd2093641749
  };

  // Signed selector codes for cos and sin of angle m*pi/7.
  localparam logic signed [3:0] COS_CODE [14] = '{
    4'sd1, 4'sd2, 4'sd4, 4'sd6, -4'sd6, -4'sd4, -4'sd2,
    -4'sd1, -4'sd2, -4'sd4, -4'sd6, 4'sd6, 4'sd4, 4'sd2
  };
  localparam logic signed [3:0] SIN_CODE [14] = '{
    4'sd0, 4'sd3, 4'sd5, 4'sd7, 4'sd7, 4'sd5, 4'sd3,
    4'sd0, -4'sd3, -4'sd5, -4'sd7, -4'sd7, -4'sd5, -4'sd3
  };

  // Command from front part to back part: which buffer holds a full frame.
  typedef struct packed {
    logic bank;
  } frame_cmd_t;

  // Back-part control state.
  typedef enum logic [1:0] {
    BK_IDLE = 2'b01,
    BK_RUN  = 2'b10
  } bk_state_t;

endpackage

/* design/dft14_complex_butterfly.sv */
// Top level of the streaming 14-point forward DFT.
// Depends on dft14_pkg, dft14_ram, dft14_front, dft14_back and the assert header.
//
// Samples enter one per cycle while busy is low; a transaction is accepted
// when start is high and busy is low. Once the 14th sample of a frame is
// accepted the frame is posted as a command, and the back part takes it
// when idle and computes 14 bins, one complex multiply-accumulate per cycle.
// Bin 0 appears once the frame is taken, its 14 samples are read and the
// sum has passed the read, product and round registers; each later bin
// follows in turn once its samples are read. The frame store is
// double-buffered: the next frame fills while the previous one is
// transformed, and a two-entry command queue tracks both buffers; busy
// rises when a second complete frame waits while the first is still being
// transformed, and falls after the last read of the running frame. Each
// bin appears for exactly one cycle with out_valid high; the receiver
// cannot stall, so capture it when the strobe is seen. Bins come in order
// 0..13, out_frame_last marks bin 13. Results are rounded to nearest, ties
// up, and never overflow.
`include "dft14_complex_butterfly_assert.svh"

module dft14_complex_butterfly #(
  parameter int SAMPLE_BITS  = 16,
  parameter int TWIDDLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [SAMPLE_BITS-1:0] in_sample_real,
  input  logic [SAMPLE_BITS-1:0] in_sample_imag,
  output logic                   out_valid,
  output logic [SAMPLE_BITS+4:0] out_bin_real,
  output logic [SAMPLE_BITS+4:0] out_bin_imag,
  output logic [3:0]             out_bin_index,
  output logic                   out_frame_last
);
  logic                     take, we, full, cmd_pop, cmd_valid;
  logic [4:0]               waddr, raddr;
  logic [2*SAMPLE_BITS-1:0] wdata, rdata;
  dft14_pkg::frame_cmd_t    cmd;

  assign busy = full;
  assign take = start && !busy;

  // accept and store samples, post full frames
  dft14_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk, .rst_n, .take, .in_sample_real, .in_sample_imag,
    .we, .waddr, .wdata, .full, .cmd_pop, .cmd_valid, .cmd
  );

  // two frame buffers of 14 samples each
  dft14_ram #(.WIDTH(2*SAMPLE_BITS), .DEPTH(32)) u_store (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  // transform one frame at a time
  dft14_back #(.SAMPLE_BITS(SAMPLE_BITS), .TWIDDLE_BITS(TWIDDLE_BITS)) u_back (
    .clk, .rst_n, .cmd_valid, .cmd, .cmd_pop, .raddr, .rdata,
    .done_valid(out_valid), .done_real(out_bin_real), .done_imag(out_bin_imag),
    .done_index(out_bin_index), .done_last(out_frame_last)
  );

  `DFT_ASSERT_IMPL(a_last_is_13, clk, rst_n, out_valid && out_frame_last, out_bin_index == 4'd13, "last bin is not 13")
  `DFT_ASSERT_NEXT(a_bin_order, clk, rst_n, out_valid && !out_frame_last, !out_valid, "bins too close")
  `DFT_ASSERT_IMPL(a_pop_valid, clk, rst_n, cmd_pop, cmd_valid, "pop from empty queue")
endmodule

/* design/dft14_ram.sv */
// Generic single-write, single-read RAM with registered read.
// No dependencies.
module dft14_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 28
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* design/dft14_front.sv */
// Front part: writes samples into the double-buffered frame store, counts
// the fill and posts a frame command into a two-entry queue. Uses dft14_pkg.
module dft14_front #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   take,
  input  logic [SAMPLE_BITS-1:0] in_sample_real,
  input  logic [SAMPLE_BITS-1:0] in_sample_imag,
  output logic                   we,
  output logic [4:0]             waddr,
  output logic [2*SAMPLE_BITS-1:0] wdata,
  output logic                   full,
  input  logic                   cmd_pop,
  output logic                   cmd_valid,
  output dft14_pkg::frame_cmd_t  cmd
);
  logic [3:0] fill_r, fill_nxt;
  logic       bank_r, bank_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       q_r [2];
  logic       qh_r, qh_nxt;
  logic       push;

  assign push  = take && (fill_r == 4'd13);
  assign we    = take;
  assign waddr = {bank_r, fill_r};
  assign wdata = {in_sample_imag, in_sample_real};
  // hold input once both buffers hold frames the back part has not finished
  assign full      = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd.bank  = q_r[qh_r];

  always_comb begin
    fill_nxt = fill_r;
    bank_nxt = bank_r;
    cnt_nxt  = cnt_r;
    qh_nxt   = qh_r;
    if (take) begin
      fill_nxt = push ? 4'd0 : fill_r + 4'd1;
      if (push) begin
        bank_nxt = ~bank_r;
      end
    end
    if (push && !cmd_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && cmd_pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
    if (cmd_pop) begin
      qh_nxt = ~qh_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 4'd0;
      bank_r <= 1'b0;
      cnt_r  <= 2'd0;
      qh_r   <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      bank_r <= bank_nxt;
      cnt_r  <= cnt_nxt;
      qh_r   <= qh_nxt;
    end
    if (push) begin
      q_r[qh_r ^ cnt_r[0]] <= bank_r;
    end
  end
endmodule

/* design/dft14_back.sv */
// Back part: for each bin, walks the 14 stored samples through one complex
// multiply-accumulate, rounds and emits the bin. Uses dft14_pkg.
module dft14_back #(
  parameter int SAMPLE_BITS  = 16,
  parameter int TWIDDLE_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cmd_valid,
  input  dft14_pkg::frame_cmd_t      cmd,
  output logic                       cmd_pop,
  output logic [4:0]                 raddr,
  input  logic [2*SAMPLE_BITS-1:0]   rdata,
  output logic                       done_valid,
  output logic [SAMPLE_BITS+4:0]     done_real,
  output logic [SAMPLE_BITS+4:0]     done_imag,
  output logic [3:0]                 done_index,
  output logic                       done_last
);
  localparam int F    = TWIDDLE_BITS - 1;
  localparam int TW   = TWIDDLE_BITS + 1;          // signed twiddle width
  localparam int PW   = SAMPLE_BITS + TW;          // product width
  localparam int AW   = PW + 5;                    // accumulator width
  localparam int OW   = SAMPLE_BITS + 5;
  localparam int SH   = 31 - F;

  dft14_pkg::bk_state_t st_r, st_nxt;
  logic       bank_r, bank_nxt;
  logic [3:0] k_r, k_nxt, n_r, n_nxt;
  logic [3:0] m_r, m_nxt;          // n*k mod 14 kept incrementally
  // pipeline: stage 1 = RAM read, stage 2 = products, stage 3 = accumulate
  logic       v1_r, v2_r, l1_r, l2_r, f1_r, f2_r;
  logic [3:0] m1_r, k1_r, k2_r;
  logic signed [TW-1:0] c1, s1;
  logic signed [PW-1:0] p_rc_r, p_is_r, p_ic_r, p_rs_r;
  logic signed [AW-1:0] acc_re_r, acc_im_r, sum_re, sum_im;
  logic signed [SAMPLE_BITS-1:0] xr, xi;

  function automatic logic signed [TW-1:0] tw(input logic signed [3:0] code);
    logic [32:0] t;
    logic [3:0]  a;
    logic signed [TW-1:0] mg;
    a  = code[3] ? 4'(-code) : code;
    t  = {1'b0, dft14_pkg::Q31_MAG[a[2:0]]};
    if (SH > 0) begin
      t = (t + (33'd1 << (SH - 1))) >> SH;
    end
    mg = TW'(t);
    return code[3] ? -mg : mg;
  endfunction

  assign xr = rdata[SAMPLE_BITS-1:0];
  assign xi = rdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign c1 = tw(dft14_pkg::COS_CODE[m1_r]);
  assign s1 = tw(dft14_pkg::SIN_CODE[m1_r]);
  assign raddr = {bank_r, n_r};
  // release the buffer with the last read of the frame
  assign cmd_pop = (st_r == dft14_pkg::BK_RUN) && (n_r == 4'd13) && (k_r == 4'd13);

  always_comb begin
    st_nxt   = st_r;
    bank_nxt = bank_r;
    k_nxt    = k_r;
    n_nxt    = n_r;
    m_nxt    = m_r;
    unique case (st_r)
      dft14_pkg::BK_IDLE: begin
        if (cmd_valid) begin
          st_nxt   = dft14_pkg::BK_RUN;
          bank_nxt = cmd.bank;
          k_nxt = 4'd0; n_nxt = 4'd0; m_nxt = 4'd0;
        end
      end
      dft14_pkg::BK_RUN: begin
        if (n_r == 4'd13) begin
          n_nxt = 4'd0;
          m_nxt = 4'd0;
          k_nxt = k_r + 4'd1;
          if (k_r == 4'd13) begin
            st_nxt = dft14_pkg::BK_IDLE;
          end
        end else begin
          n_nxt = n_r + 4'd1;
          // advance angle by k modulo 14
          m_nxt = ({1'b0, m_r} + {1'b0, k_r} >= 5'd14) ? m_r + k_r - 4'd14 : m_r + k_r;
        end
      end
      default: st_nxt = dft14_pkg::BK_IDLE;
    endcase
  end

  assign sum_re = (f2_r ? AW'(0) : acc_re_r) + AW'(p_rc_r) + AW'(p_is_r);
  assign sum_im = (f2_r ? AW'(0) : acc_im_r) + AW'(p_ic_r) - AW'(p_rs_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= dft14_pkg::BK_IDLE;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      done_valid <= 1'b0;
    end else begin
      st_r <= st_nxt;
      v1_r <= (st_r == dft14_pkg::BK_RUN);
      v2_r <= v1_r;
      done_valid <= v2_r && l2_r;
    end
    bank_r <= bank_nxt;
    k_r <= k_nxt; n_r <= n_nxt; m_r <= m_nxt;
    m1_r <= m_r; k1_r <= k_r;
    l1_r <= (n_r == 4'd13); f1_r <= (n_r == 4'd0);
    p_rc_r <= PW'(xr * c1);
    p_is_r <= PW'(xi * s1);
    p_ic_r <= PW'(xi * c1);
    p_rs_r <= PW'(xr * s1);
    l2_r <= l1_r; f2_r <= f1_r; k2_r <= k1_r;
    if (v2_r) begin
      acc_re_r <= sum_re;
      acc_im_r <= sum_im;
    end
    // round to nearest, ties up
    done_real  <= OW'((sum_re + (AW'(1) <<< (F - 1))) >>> F);
    done_imag  <= OW'((sum_im + (AW'(1) <<< (F - 1))) >>> F);
    done_index <= k2_r;
    done_last  <= (k2_r == 4'd13);
  end
endmodule
